>>> rtl/assert_macros.svh
// Assertion macros shared by the block structure matcher RTL.
// No dependencies; define NO_ASSERTIONS to compile the checks out.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
// Clocked check that is switched off while reset is held.
`define BSM_ASSERT(name, clk, rst_n, prop) \
    name: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("%m: assertion failed");
// Clocked check that also holds while reset is held.
`define BSM_ASSERT_ALWAYS(name, clk, prop) \
    name: assert property (@(posedge clk) prop) else $error("%m: assertion failed");
`else
`define BSM_ASSERT(name, clk, rst_n, prop)
`define BSM_ASSERT_ALWAYS(name, clk, prop)
`endif
`endif

>>> rtl/bsm_pkg.sv
// Types and codes for the block structure matcher.
// No dependencies.
package bsm_pkg;

    // Line type codes of an input transfer.
    localparam logic [3:0] LT_OTHER    = 4'd0;
    localparam logic [3:0] LT_BEGIN    = 4'd1;
    localparam logic [3:0] LT_IF       = 4'd2;
    localparam logic [3:0] LT_WHILE    = 4'd3;
    localparam logic [3:0] LT_FOR      = 4'd4;
    localparam logic [3:0] LT_REPEAT   = 4'd5;
    localparam logic [3:0] LT_END      = 4'd6;
    localparam logic [3:0] LT_ENDIF    = 4'd7;
    localparam logic [3:0] LT_ELSE     = 4'd8;
    localparam logic [3:0] LT_ENDWHILE = 4'd9;
    localparam logic [3:0] LT_ENDFOR   = 4'd10;
    localparam logic [3:0] LT_UNTIL    = 4'd11;

    // Record kinds of an output transfer.
    localparam logic [1:0] RK_LINK    = 2'd0;
    localparam logic [1:0] RK_ERROR   = 2'd1;
    localparam logic [1:0] RK_SUMMARY = 2'd2;

    // Link fields.
    localparam logic [1:0] LF_BEGIN  = 2'd0;
    localparam logic [1:0] LF_MIDDLE = 2'd1;
    localparam logic [1:0] LF_END    = 2'd2;

    typedef struct packed {
        logic [3:0]  line_type;
        logic [9:0]  line_index;
        logic [15:0] source_line;
        logic        final_line;
    } t_in_item;

    typedef struct packed {
        logic [1:0]  record_kind;
        logic [9:0]  target_index;
        logic [1:0]  link_field;
        logic [9:0]  link_value;
        logic [15:0] error_line;
        logic        pass_ok;
        logic        last_of_run;
    } t_out_item;

    // One stack entry: opener kind, its index and the latest else under it.
    typedef struct packed {
        logic [2:0] kind;
        logic [9:0] position;
        logic       mid_valid;
        logic [9:0] middle;
    } t_stack_entry;

    // Which group of link writes a line causes.
    typedef enum logic [1:0] {
        LM_NONE       = 2'd0,
        LM_ELSE       = 2'd1,
        LM_CLOSE      = 2'd2,
        LM_CLOSE_ELSE = 2'd3
    } t_link_mode;

    // Opener kind that a closer or an else expects on top of the stack.
    function automatic logic [2:0] want_kind(input logic [3:0] line_type);
        logic [2:0] k;
        case (line_type)
            LT_END:      k = LT_BEGIN[2:0];
            LT_ENDIF:    k = LT_IF[2:0];
            LT_ELSE:     k = LT_IF[2:0];
            LT_ENDWHILE: k = LT_WHILE[2:0];
            LT_ENDFOR:   k = LT_FOR[2:0];
            default:     k = LT_REPEAT[2:0];
        endcase
        return k;
    endfunction

endpackage

>>> rtl/block_structure_matcher_unit.sv
// Block structure matcher: bracket stack, link write sequencer and output register.
// Depends on bsm_pkg and assert_macros.svh.
//
//  channel | direction | handshake             | payload
//  --------+-----------+-----------------------+-------------------------
//  in      | input     | i_in_valid/o_in_stall  | i_in_data  (t_in_item)
//  out     | output    | o_out_valid/i_out_stall| o_out_data (t_out_item)
//
// An opener that fits on the stack, or an other line, without the final flag yields
// no records, so such lines pass at one per cycle unless a refill holds them. A line
// with results gives the sequencer a run of one to seven records; the next line waits
// for it only when a second such line finds it busy. A pop leaving entries behind
// holds the next line while the new top is read from the stack memory's registered port.
// Reset clears the stack pointer and error flag at once; there is no clearing pass.
// A stall on a valid output record holds the output register and the sequencer in place.
`include "assert_macros.svh"

module block_structure_matcher_unit #(
    parameter int STACK_DEPTH = 64
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  bsm_pkg::t_in_item   i_in_data,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output bsm_pkg::t_out_item  o_out_data
);

    localparam int SP_W  = $clog2(STACK_DEPTH + 1);
    localparam int IDX_W = $clog2(STACK_DEPTH);

    // Input register.
    logic              r_in_valid;
    bsm_pkg::t_in_item r_in;

    // Stack: top entry in flops, the rest in memory.
    logic [SP_W-1:0]       r_sp, n_sp;
    bsm_pkg::t_stack_entry r_top, n_top;
    bsm_pkg::t_stack_entry r_mem [STACK_DEPTH];
    bsm_pkg::t_stack_entry r_rd_data;
    logic                  r_refill;
    logic                  r_err_seen, n_err_seen;

    // Result descriptor for the sequencer.
    logic                r_d_valid;
    logic                r_d_err, n_d_err;
    bsm_pkg::t_link_mode r_d_mode, n_d_mode;
    logic                r_d_sum;
    logic                r_d_ok, n_d_ok;
    logic [9:0]          r_d_open, r_d_idx, r_d_els;
    logic [15:0]         r_d_sline;
    logic [2:0]          r_d_count, n_d_count;
    logic [2:0]          r_step;

    // Output register.
    logic               r_out_valid;
    bsm_pkg::t_out_item r_out, n_rec;

    logic            is_open, is_close, top_match, wr_en, pop, needs_desc;
    logic [SP_W-1:0] sp_m1, sp_m2;
    logic            proc_go, desc_done, emit_go, in_take;

    // Stack update and result classification for the registered line.
    always_comb begin
        is_open    = (r_in.line_type >= bsm_pkg::LT_BEGIN) &&
                     (r_in.line_type <= bsm_pkg::LT_REPEAT);
        is_close   = (r_in.line_type >= bsm_pkg::LT_END) &&
                     (r_in.line_type <= bsm_pkg::LT_UNTIL);
        top_match  = (r_sp != '0) && (r_top.kind == bsm_pkg::want_kind(r_in.line_type));
        sp_m1      = r_sp - SP_W'(1);
        sp_m2      = r_sp - SP_W'(2);
        n_sp       = r_sp;
        n_top      = r_top;
        wr_en      = 1'b0;
        pop        = 1'b0;
        n_d_err    = 1'b0;
        n_d_mode   = bsm_pkg::LM_NONE;
        if (is_open) begin
            if (r_sp >= SP_W'(STACK_DEPTH)) begin
                n_d_err = 1'b1;
            end else begin
                wr_en          = (r_sp != '0);
                n_top.kind     = r_in.line_type[2:0];
                n_top.position = r_in.line_index;
                n_top.mid_valid = 1'b0;
                n_top.middle   = '0;
                n_sp           = r_sp + SP_W'(1);
            end
        end else if (is_close) begin
            if (!top_match) begin
                n_d_err = 1'b1;
            end else if (r_in.line_type == bsm_pkg::LT_ELSE) begin
                n_top.mid_valid = 1'b1;
                n_top.middle    = r_in.line_index;
                n_d_mode        = bsm_pkg::LM_ELSE;
            end else begin
                pop  = 1'b1;
                n_sp = sp_m1;
                if (r_in.line_type == bsm_pkg::LT_ENDIF && r_top.mid_valid) begin
                    n_d_mode = bsm_pkg::LM_CLOSE_ELSE;
                end else begin
                    n_d_mode = bsm_pkg::LM_CLOSE;
                end
            end
        end
        n_err_seen = r_err_seen | n_d_err;
        n_d_ok     = !n_err_seen;
        if (r_in.final_line) begin
            n_sp       = '0;
            n_err_seen = 1'b0;
        end
        case (n_d_mode)
            bsm_pkg::LM_ELSE:       n_d_count = 3'd3;
            bsm_pkg::LM_CLOSE:      n_d_count = 3'd4;
            bsm_pkg::LM_CLOSE_ELSE: n_d_count = 3'd6;
            default:                n_d_count = n_d_err ? 3'd1 : 3'd0;
        endcase
        n_d_count  = n_d_count + {2'b00, r_in.final_line};
        needs_desc = n_d_err || (n_d_mode != bsm_pkg::LM_NONE) || r_in.final_line;
    end

    // Handshake and pipeline control.
    assign emit_go    = r_d_valid && (!r_out_valid || !i_out_stall);
    assign desc_done  = emit_go && (r_step == r_d_count - 3'd1);
    assign proc_go    = r_in_valid && !r_refill && (!needs_desc || !r_d_valid || desc_done);
    assign o_in_stall = r_in_valid && !proc_go;
    assign in_take    = i_in_valid && !o_in_stall;

    // Input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_take) begin
            r_in_valid <= 1'b1;
        end else if (proc_go) begin
            r_in_valid <= 1'b0;
        end
        if (in_take) begin
            r_in <= i_in_data;
        end
    end

    // Stack memory: pushes spill the old top, the entry below the top is read each cycle.
    always_ff @(posedge i_clk) begin
        if (proc_go && wr_en) begin
            r_mem[sp_m1[IDX_W-1:0]] <= r_top;
        end
        r_rd_data <= r_mem[sp_m2[IDX_W-1:0]];
    end

    // Stack pointer, top entry, refill and error flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sp       <= '0;
            r_refill   <= 1'b0;
            r_err_seen <= 1'b0;
        end else if (r_refill) begin
            r_refill <= 1'b0;
        end else if (proc_go) begin
            r_sp       <= n_sp;
            r_refill   <= pop && (n_sp != '0);
            r_err_seen <= n_err_seen;
        end
        if (r_refill) begin
            r_top <= r_rd_data;
        end else if (proc_go) begin
            r_top <= n_top;
        end
    end

    // Descriptor load and sequencer step.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_d_valid <= 1'b0;
            r_step    <= '0;
        end else if (proc_go && needs_desc) begin
            r_d_valid <= 1'b1;
            r_step    <= '0;
        end else if (desc_done) begin
            r_d_valid <= 1'b0;
            r_step    <= '0;
        end else if (emit_go) begin
            r_step <= r_step + 3'd1;
        end
        if (proc_go && needs_desc) begin
            r_d_err   <= n_d_err;
            r_d_mode  <= n_d_mode;
            r_d_sum   <= r_in.final_line;
            r_d_ok    <= n_d_ok;
            r_d_open  <= r_top.position;
            r_d_idx   <= r_in.line_index;
            r_d_els   <= r_top.middle;
            r_d_sline <= r_in.source_line;
            r_d_count <= n_d_count;
        end
    end

    // Record for the current sequencer step.
    always_comb begin
        n_rec             = '0;
        n_rec.last_of_run = (r_step == r_d_count - 3'd1);
        if (r_d_sum && n_rec.last_of_run) begin
            n_rec.record_kind = bsm_pkg::RK_SUMMARY;
            n_rec.pass_ok     = r_d_ok;
        end else if (r_d_err) begin
            n_rec.record_kind = bsm_pkg::RK_ERROR;
            n_rec.error_line  = r_d_sline;
        end else if (r_d_mode == bsm_pkg::LM_ELSE) begin
            n_rec.record_kind = bsm_pkg::RK_LINK;
            case (r_step)
                3'd0: begin
                    n_rec.target_index = r_d_open;
                    n_rec.link_field   = bsm_pkg::LF_MIDDLE;
                    n_rec.link_value   = r_d_idx;
                end
                3'd1: begin
                    n_rec.target_index = r_d_idx;
                    n_rec.link_field   = bsm_pkg::LF_BEGIN;
                    n_rec.link_value   = r_d_open;
                end
                default: begin
                    n_rec.target_index = r_d_idx;
                    n_rec.link_field   = bsm_pkg::LF_MIDDLE;
                    n_rec.link_value   = r_d_idx;
                end
            endcase
        end else begin
            n_rec.record_kind = bsm_pkg::RK_LINK;
            case (r_step)
                3'd0: begin
                    n_rec.target_index = r_d_open;
                    n_rec.link_field   = bsm_pkg::LF_BEGIN;
                    n_rec.link_value   = r_d_open;
                end
                3'd1: begin
                    n_rec.target_index = r_d_open;
                    n_rec.link_field   = bsm_pkg::LF_END;
                    n_rec.link_value   = r_d_idx;
                end
                3'd2: begin
                    n_rec.target_index = r_d_idx;
                    n_rec.link_field   = bsm_pkg::LF_BEGIN;
                    n_rec.link_value   = r_d_open;
                end
                3'd3: begin
                    n_rec.target_index = r_d_idx;
                    n_rec.link_field   = bsm_pkg::LF_END;
                    n_rec.link_value   = r_d_idx;
                end
                3'd4: begin
                    n_rec.target_index = r_d_idx;
                    n_rec.link_field   = bsm_pkg::LF_MIDDLE;
                    n_rec.link_value   = r_d_els;
                end
                default: begin
                    n_rec.target_index = r_d_els;
                    n_rec.link_field   = bsm_pkg::LF_END;
                    n_rec.link_value   = r_d_idx;
                end
            endcase
        end
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (emit_go) begin
            r_out_valid <= 1'b1;
        end else if (r_out_valid && !i_out_stall) begin
            r_out_valid <= 1'b0;
        end
        if (emit_go) begin
            r_out <= n_rec;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // The stack pointer never passes the stack depth.
    `BSM_ASSERT(a_sp_range, i_clk, i_rst_n, r_sp <= SP_W'(STACK_DEPTH))
    // A refill only happens with entries left on the stack.
    `BSM_ASSERT(a_refill_nonempty, i_clk, i_rst_n, r_refill |-> (r_sp != '0))
    // No line is processed while the top entry is being refilled.
    `BSM_ASSERT(a_no_proc_in_refill, i_clk, i_rst_n, r_refill |-> !proc_go)
    // The sequencer step stays inside the loaded run.
    `BSM_ASSERT(a_step_in_run, i_clk, i_rst_n, r_d_valid |-> (r_step < r_d_count))
    // A pop that leaves entries behind is followed by a refill.
    `BSM_ASSERT(a_pop_refills, i_clk, i_rst_n,
        (proc_go && !r_refill && pop && (n_sp != '0)) |=> r_refill)

endmodule

>>> verif/testbench.sv
`timescale 1ns / 1ps
// Self-checking testbench for block_structure_matcher_unit: a queue-fed driver, a
// result monitor and a bracket-stack predictor of the link, error and summary records.
// Depends on bsm_pkg and the RTL of the block.
module testbench;

    localparam int NEST_DEPTH   = 64;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int HOLD_AFTER   = 60;
    localparam int HOLD_CYCLES  = 300;
    localparam int DRAIN_CYCLES = 40;
    localparam int RANDOM_LINES = 106;

    logic               i_clk       = 1'b0;
    logic               i_rst_n     = 1'b0;
    logic               i_in_valid  = 1'b0;
    logic               i_out_stall = 1'b0;
    bsm_pkg::t_in_item  i_in_data   = '0;
    logic               o_in_stall;
    logic               o_out_valid;
    bsm_pkg::t_out_item o_out_data;

    block_structure_matcher_unit #(.STACK_DEPTH(NEST_DEPTH)) DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

    // 10 ns clock.
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Lines waiting to be offered and records waiting to arrive.
    bsm_pkg::t_in_item  pending_lines[$];
    bsm_pkg::t_out_item expected_records[$];

    // Predictor state: the bracket stack and the error flag of the current pass.
    bsm_pkg::t_stack_entry nest_stack [NEST_DEPTH];
    int                    nest_count  = 0;
    bit                    pass_failed = 1'b0;

    // Stimulus bookkeeping.
    logic [9:0] next_index = '0;
    int         random_made = 0;

    // Run statistics.
    int fail_count      = 0;
    int lines_sent      = 0;
    int records_checked = 0;
    int links_seen      = 0;
    int errors_seen     = 0;
    int summaries_seen  = 0;
    int blocked_cycles  = 0;

    // Handshake pacing.
    int gap_left   = 0;
    int stall_left = 0;
    int hold_left  = 0;
    bit hold_done  = 1'b0;

    function automatic bsm_pkg::t_out_item make_record(logic [1:0] kind, logic [9:0] target,
                                                       logic [1:0] field, logic [9:0] value,
                                                       logic [15:0] eline, logic ok);
        bsm_pkg::t_out_item rec;
        rec.record_kind  = kind;
        rec.target_index = target;
        rec.link_field   = field;
        rec.link_value   = value;
        rec.error_line   = eline;
        rec.pass_ok      = ok;
        rec.last_of_run  = 1'b0;
        return rec;
    endfunction

    // Opener kind that a closing line or an else must find on top of the stack.
    function automatic logic [3:0] opener_for(logic [3:0] closer);
        case (closer)
            bsm_pkg::LT_END:                    return bsm_pkg::LT_BEGIN;
            bsm_pkg::LT_ENDIF, bsm_pkg::LT_ELSE: return bsm_pkg::LT_IF;
            bsm_pkg::LT_ENDWHILE:               return bsm_pkg::LT_WHILE;
            bsm_pkg::LT_ENDFOR:                 return bsm_pkg::LT_FOR;
            default:                            return bsm_pkg::LT_REPEAT;
        endcase
    endfunction

    // Closing line that pops a given opener kind.
    function automatic logic [3:0] closer_for(logic [3:0] opener);
        case (opener)
            bsm_pkg::LT_BEGIN: return bsm_pkg::LT_END;
            bsm_pkg::LT_IF:    return bsm_pkg::LT_ENDIF;
            bsm_pkg::LT_WHILE: return bsm_pkg::LT_ENDWHILE;
            bsm_pkg::LT_FOR:   return bsm_pkg::LT_ENDFOR;
            default:           return bsm_pkg::LT_UNTIL;
        endcase
    endfunction

    // Works out the records that one accepted line causes and updates the stack.
    task automatic predict_line(input bsm_pkg::t_in_item item);
        bsm_pkg::t_out_item    recs[$];
        bsm_pkg::t_stack_entry top;
        logic [9:0]            opener_at;
        logic [9:0]            else_at;
        if (item.line_type >= bsm_pkg::LT_BEGIN && item.line_type <= bsm_pkg::LT_REPEAT) begin
            if (nest_count >= NEST_DEPTH) begin
                recs.push_back(make_record(bsm_pkg::RK_ERROR, '0, bsm_pkg::LF_BEGIN, '0,
                                           item.source_line, 1'b0));
                pass_failed = 1'b1;
            end else begin
                nest_stack[nest_count].kind      = item.line_type[2:0];
                nest_stack[nest_count].position  = item.line_index;
                nest_stack[nest_count].mid_valid = 1'b0;
                nest_stack[nest_count].middle    = '0;
                nest_count++;
            end
        end else if (item.line_type >= bsm_pkg::LT_END &&
                     item.line_type <= bsm_pkg::LT_UNTIL) begin
            if (nest_count == 0 ||
                {1'b0, nest_stack[nest_count - 1].kind} != opener_for(item.line_type)) begin
                recs.push_back(make_record(bsm_pkg::RK_ERROR, '0, bsm_pkg::LF_BEGIN, '0,
                                           item.source_line, 1'b0));
                pass_failed = 1'b1;
            end else begin
                top       = nest_stack[nest_count - 1];
                opener_at = top.position;
                if (item.line_type == bsm_pkg::LT_ELSE) begin
                    // The latest else under an if becomes its middle link.
                    nest_stack[nest_count - 1].mid_valid = 1'b1;
                    nest_stack[nest_count - 1].middle    = item.line_index;
                    recs.push_back(make_record(bsm_pkg::RK_LINK, opener_at, bsm_pkg::LF_MIDDLE,
                                               item.line_index, '0, 1'b0));
                    recs.push_back(make_record(bsm_pkg::RK_LINK, item.line_index,
                                               bsm_pkg::LF_BEGIN, opener_at, '0, 1'b0));
                    recs.push_back(make_record(bsm_pkg::RK_LINK, item.line_index,
                                               bsm_pkg::LF_MIDDLE, item.line_index, '0, 1'b0));
                end else begin
                    nest_count--;
                    recs.push_back(make_record(bsm_pkg::RK_LINK, opener_at, bsm_pkg::LF_BEGIN,
                                               opener_at, '0, 1'b0));
                    recs.push_back(make_record(bsm_pkg::RK_LINK, opener_at, bsm_pkg::LF_END,
                                               item.line_index, '0, 1'b0));
                    recs.push_back(make_record(bsm_pkg::RK_LINK, item.line_index,
                                               bsm_pkg::LF_BEGIN, opener_at, '0, 1'b0));
                    recs.push_back(make_record(bsm_pkg::RK_LINK, item.line_index,
                                               bsm_pkg::LF_END, item.line_index, '0, 1'b0));
                    // An endif whose if saw an else also ties the else to the endif.
                    if (item.line_type == bsm_pkg::LT_ENDIF && top.mid_valid) begin
                        else_at = top.middle;
                        recs.push_back(make_record(bsm_pkg::RK_LINK, item.line_index,
                                                   bsm_pkg::LF_MIDDLE, else_at, '0, 1'b0));
                        recs.push_back(make_record(bsm_pkg::RK_LINK, else_at, bsm_pkg::LF_END,
                                                   item.line_index, '0, 1'b0));
                    end
                end
            end
        end

        // The last line of a pass adds the summary and empties the stack.
        if (item.final_line) begin
            recs.push_back(make_record(bsm_pkg::RK_SUMMARY, '0, bsm_pkg::LF_BEGIN, '0, '0,
                                       !pass_failed));
            nest_count  = 0;
            pass_failed = 1'b0;
        end

        if (recs.size() != 0) recs[recs.size() - 1].last_of_run = 1'b1;
        foreach (recs[k]) expected_records.push_back(recs[k]);
    endtask

    task automatic compare_field(input string name, input int unsigned want,
                                 input int unsigned got);
        if (want != got) begin
            $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h",
                     $time, name, want, got);
            fail_count++;
        end
    endtask

    // Checks one received record against the oldest expectation.
    task automatic check_record(input bsm_pkg::t_out_item got);
        bsm_pkg::t_out_item want;
        if (expected_records.size() == 0) begin
            $display("%0t: unexpected record, expected none, actual 0x%0h", $time, got);
            fail_count++;
        end else begin
            want = expected_records.pop_front();
            compare_field("record_kind",  want.record_kind,  got.record_kind);
            compare_field("target_index", want.target_index, got.target_index);
            compare_field("link_field",   want.link_field,   got.link_field);
            compare_field("link_value",   want.link_value,   got.link_value);
            compare_field("error_line",   want.error_line,   got.error_line);
            compare_field("pass_ok",      want.pass_ok,      got.pass_ok);
            compare_field("last_of_run",  want.last_of_run,  got.last_of_run);
        end
        records_checked++;
        if (got.record_kind == bsm_pkg::RK_LINK)    links_seen++;
        if (got.record_kind == bsm_pkg::RK_ERROR)   errors_seen++;
        if (got.record_kind == bsm_pkg::RK_SUMMARY) summaries_seen++;
    endtask

    // Mostly short gaps, a few long ones, none at all in calm stretches.
    function automatic int pick_gap(bit calm);
        int roll;
        roll = $urandom_range(0, 99);
        if (calm || roll < 60) return 0;
        if (roll < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    task automatic add_line(input logic [3:0] kind, input logic [9:0] index,
                            input logic [15:0] src, input logic last);
        bsm_pkg::t_in_item item;
        item.line_type   = kind;
        item.line_index  = index;
        item.source_line = src;
        item.final_line  = last;
        pending_lines.push_back(item);
    endtask

    task automatic add_random_line(input logic [3:0] kind, input logic last);
        add_line(kind, next_index, 16'($urandom_range(0, 65535)), last);
        next_index++;
        random_made++;
    endtask

    // One pass of a program: mostly well-nested blocks with random content, some
    // noise lines, and now and then a pass that ends with blocks left open. The
    // overflow form nests past the stack depth before closing a few blocks.
    task automatic queue_program(input int body_lines, input bit overflow);
        logic [3:0] opens[$];
        logic [3:0] kind;
        int         made;
        int         roll;
        int         to_close;
        made       = 0;
        next_index = 10'($urandom_range(0, 1023));
        while (made < body_lines) begin
            roll = $urandom_range(0, 99);
            if (overflow || (roll >= 8 && roll < 40 && opens.size() < 12))
                kind = 4'($urandom_range(bsm_pkg::LT_BEGIN, bsm_pkg::LT_REPEAT));
            else if (roll < 8)
                kind = 4'($urandom_range(0, 15));
            else if (roll < 55)
                kind = bsm_pkg::LT_OTHER;
            else if (opens.size() == 0)
                kind = 4'($urandom_range(bsm_pkg::LT_BEGIN, bsm_pkg::LT_REPEAT));
            else if (opens[$] == bsm_pkg::LT_IF && roll < 70)
                kind = bsm_pkg::LT_ELSE;
            else
                kind = closer_for(opens[$]);

            // Keep the view of the stack that the generator aims at in step.
            if (kind >= bsm_pkg::LT_BEGIN && kind <= bsm_pkg::LT_REPEAT) begin
                if (opens.size() < NEST_DEPTH) opens.push_back(kind);
            end else if (kind >= bsm_pkg::LT_END && kind <= bsm_pkg::LT_UNTIL &&
                         kind != bsm_pkg::LT_ELSE &&
                         opens.size() != 0 && closer_for(opens[$]) == kind) begin
                void'(opens.pop_back());
            end
            add_random_line(kind, 1'b0);
            made++;
        end

        if (overflow) to_close = 3;
        else if ($urandom_range(0, 4) == 0) to_close = $urandom_range(0, 1);
        else to_close = opens.size();
        while (to_close > 1 && opens.size() > 1) begin
            add_random_line(closer_for(opens.pop_back()), 1'b0);
            to_close--;
        end

        // The final flag rides on a closer, a plain line or a noise line.
        roll = $urandom_range(0, 2);
        if (opens.size() != 0 && roll == 0)
            add_random_line(closer_for(opens[$]), 1'b1);
        else if (roll == 1)
            add_random_line(bsm_pkg::LT_OTHER, 1'b1);
        else
            add_random_line(4'($urandom_range(0, 15)), 1'b1);
    endtask

    task automatic queue_directed();
        // Closer and else on an empty stack.
        add_line(bsm_pkg::LT_END,  10'd3,    16'hFFFF, 1'b0);
        add_line(bsm_pkg::LT_ELSE, 10'd4,    16'h0000, 1'b0);
        // Index extremes on a begin/end pair.
        add_line(bsm_pkg::LT_BEGIN, 10'd0,    16'h0001, 1'b0);
        add_line(bsm_pkg::LT_END,   10'd1023, 16'h0002, 1'b0);
        // Repeated else under one if, the latest one wins.
        add_line(bsm_pkg::LT_IF,    10'd5,  16'h0005, 1'b0);
        add_line(bsm_pkg::LT_ELSE,  10'd6,  16'h0006, 1'b0);
        add_line(bsm_pkg::LT_ELSE,  10'd7,  16'h0007, 1'b0);
        add_line(bsm_pkg::LT_ENDIF, 10'd8,  16'h0008, 1'b0);
        // Every other kind of block, nested.
        add_line(bsm_pkg::LT_WHILE,    10'd9,  16'h0009, 1'b0);
        add_line(bsm_pkg::LT_FOR,      10'd10, 16'h000A, 1'b0);
        add_line(bsm_pkg::LT_REPEAT,   10'd11, 16'h000B, 1'b0);
        add_line(bsm_pkg::LT_UNTIL,    10'd12, 16'h000C, 1'b0);
        add_line(bsm_pkg::LT_ENDFOR,   10'd13, 16'h000D, 1'b0);
        add_line(bsm_pkg::LT_ENDWHILE, 10'd14, 16'h000E, 1'b0);
        // Mismatched closer, then an if closed without an else on the final line.
        add_line(bsm_pkg::LT_IF,       10'd15, 16'h000F, 1'b0);
        add_line(bsm_pkg::LT_ENDWHILE, 10'd16, 16'hA5A5, 1'b0);
        add_line(bsm_pkg::LT_ENDIF,    10'd17, 16'h0011, 1'b1);
        // A plain line and two of the unused type codes.
        add_line(bsm_pkg::LT_OTHER, 10'd18,   16'h0012, 1'b0);
        add_line(4'd12,             10'd1023, 16'hFFFF, 1'b0);
        add_line(4'd15,             10'd20,   16'h5A5A, 1'b0);
        // A final line clears a block left open.
        add_line(bsm_pkg::LT_BEGIN, 10'd21, 16'h0015, 1'b0);
        add_line(bsm_pkg::LT_OTHER, 10'd22, 16'h0016, 1'b1);
        add_line(bsm_pkg::LT_END,   10'd23, 16'h0017, 1'b0);
        add_line(bsm_pkg::LT_OTHER, 10'd24, 16'h0018, 1'b1);
    endtask

    // Sender: offers queued lines, keeps a stalled transfer steady, idles at random.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
            gap_left   <= 0;
        end else begin
            if (i_in_valid && !o_in_stall) begin
                predict_line(i_in_data);
                lines_sent <= lines_sent + 1;
            end
            if (i_in_valid && o_in_stall) begin
                blocked_cycles <= blocked_cycles + 1;
            end else if (gap_left > 0) begin
                gap_left   <= gap_left - 1;
                i_in_valid <= 1'b0;
            end else if (pending_lines.size() != 0) begin
                i_in_data  <= pending_lines.pop_front();
                i_in_valid <= 1'b1;
                gap_left   <= pick_gap((lines_sent / 20) % 3 == 0);
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // One long hold-off of the receiver, so that the block fills and stalls its input.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            hold_left <= 0;
            hold_done <= 1'b0;
        end else if (!hold_done && lines_sent >= HOLD_AFTER) begin
            hold_left <= HOLD_CYCLES;
            hold_done <= 1'b1;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end
    end

    // Receiver: checks each record transfer and stalls at random.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
            stall_left  <= 0;
        end else begin
            if (o_out_valid && !i_out_stall) check_record(o_out_data);
            i_out_stall <= (hold_left != 0) || (stall_left != 0);
            if (stall_left != 0) stall_left <= stall_left - 1;
            else stall_left <= pick_gap((records_checked / 25) % 3 == 1);
        end
    end

    // Stimulus, reset and end of run.
    initial begin
        queue_directed();
        while (random_made < 20) queue_program($urandom_range(3, 14), 1'b0);
        queue_program(NEST_DEPTH + 2, 1'b1);
        while (random_made < RANDOM_LINES) queue_program($urandom_range(3, 14), 1'b0);

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (pending_lines.size() != 0 || i_in_valid) @(posedge i_clk);
        while (expected_records.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Run covered %0d lines in, %0d records out: %0d links, %0d errors,",
                 lines_sent, records_checked, links_seen, errors_seen);
        $display("%0d summaries; overflow pass and long output hold done, input stalled %0d cycles.",
                 summaries_seen, blocked_cycles);
        if (fail_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

    // Watchdog on the total number of cycles.
    initial begin
        int cycles;
        cycles = 0;
        while (cycles < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycles++;
        end
        $display("%0t: timeout after %0d cycles", $time, cycles);
        $display("Some tests failed");
        $finish;
    end

endmodule

>>> filelist.f
+incdir+rtl
rtl/bsm_pkg.sv
rtl/block_structure_matcher_unit.sv
verif/testbench.sv
